// ===== rtl/dht_pulse_frame_decoder_macros.svh =====
// assertion macros for the pulse frame decoder
`ifndef DHT_PULSE_FRAME_DECODER_MACROS_SVH
`define DHT_PULSE_FRAME_DECODER_MACROS_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define DHTPFD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dhtpfd same-cycle check failed");

// next-cycle implication
`define DHTPFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dhtpfd next-cycle check failed");

`endif

// ===== rtl/dhtpfd_pkg.sv =====
// shared types and constants of the pulse frame decoder
package dhtpfd_pkg;

   localparam int DEFAULT_COUNTER_WIDTH = 16;
   localparam int FIELD_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COUNTER_TOP   = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RESPONSE_MIN  = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RESPONSE_MAX  = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ONE_THRESHOLD = 8'd3;

   localparam logic [FIELD_WIDTH-1:0] COUNTER_TOP_RESET   = 16'hFFFF;
   localparam logic [FIELD_WIDTH-1:0] RESPONSE_MIN_RESET  = 16'd70;
   localparam logic [FIELD_WIDTH-1:0] RESPONSE_MAX_RESET  = 16'd95;
   localparam logic [FIELD_WIDTH-1:0] ONE_THRESHOLD_RESET = 16'd50;

   localparam logic OP_CAPTURE = 1'b0;
   localparam logic OP_ARM     = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_CHECKSUM   = 2'd1,
      STATUS_UNEXPECTED = 2'd2
   } status_type;

endpackage

// ===== rtl/dhtpfd_channels.sv =====
// valid/ready channel interfaces of the pulse frame decoder
interface dhtpfd_req_if
   import dhtpfd_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic                   op;
   logic [FIELD_WIDTH-1:0] capture_value;
   logic                   line_high;

   modport source (output valid, output op, output capture_value, output line_high,
                   input ready);
   modport sink   (input valid, input op, input capture_value, input line_high,
                   output ready);
endinterface

interface dhtpfd_rsp_if
   import dhtpfd_pkg::*;
   ;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [FIELD_WIDTH-1:0]        humidity_tenths;
   logic signed [FIELD_WIDTH-1:0] temperature_tenths;

   modport source (output valid, output status, output humidity_tenths,
                   output temperature_tenths, input ready);
   modport sink   (input valid, input status, input humidity_tenths,
                   input temperature_tenths, output ready);
endinterface

interface dhtpfd_csr_if
   import dhtpfd_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [FIELD_WIDTH-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/dhtpfd_interval.sv =====
// wrapped capture interval against the previous capture
module dhtpfd_interval
   import dhtpfd_pkg::*;
#(
   parameter int COUNTER_WIDTH = DEFAULT_COUNTER_WIDTH
) (
   input  logic [FIELD_WIDTH-1:0] capture_value,
   input  logic [FIELD_WIDTH-1:0] prev_capture,
   input  logic [FIELD_WIDTH-1:0] counter_top,
   output logic [FIELD_WIDTH-1:0] capture_masked,
   output logic [FIELD_WIDTH-1:0] interval
);

   localparam int MASK_WIDTH = (COUNTER_WIDTH < FIELD_WIDTH) ? COUNTER_WIDTH : FIELD_WIDTH;
   localparam logic [FIELD_WIDTH:0] MASK_WIDE = (17'd1 << MASK_WIDTH) - 17'd1;
   localparam logic [FIELD_WIDTH-1:0] CNT_MASK = MASK_WIDE[FIELD_WIDTH-1:0];

   logic [FIELD_WIDTH-1:0]  top_masked;
   logic signed [FIELD_WIDTH+1:0] wrap_sum;

   assign capture_masked = capture_value & CNT_MASK;
   assign top_masked     = counter_top & CNT_MASK;

   // one wrap of the counter; negative only if previous sat above the top
   assign wrap_sum = $signed({2'b00, top_masked}) - $signed({2'b00, prev_capture})
                   + $signed({2'b00, capture_masked}) + 18'sd1;

   always_comb begin
      if (capture_masked >= prev_capture) begin
         interval = capture_masked - prev_capture;
      end else if (wrap_sum < 18'sd0) begin
         interval = '0;
      end else begin
         interval = wrap_sum[FIELD_WIDTH-1:0];
      end
   end

endmodule

// ===== rtl/dht_pulse_frame_decoder.sv =====
// top level of the pulse frame decoder
// two register stages: the input stage, then the result register that drives rsp
// throughput: one req word per cycle while no result waits on a stalled rsp port
// words that produce no result (arm, line high, response edge, bit before the checksum) leave rsp untouched
// reset: synchronous active high; phase goes to finished, counters and config to defaults
`include "dht_pulse_frame_decoder_macros.svh"

module dht_pulse_frame_decoder
   import dhtpfd_pkg::*;
#(
   parameter int COUNTER_WIDTH = DEFAULT_COUNTER_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   dhtpfd_req_if.sink   req_port,
   dhtpfd_rsp_if.source rsp_port,
   dhtpfd_csr_if.sink   csr_port
);

   typedef enum logic [1:0] {
      PH_RESPONSE = 2'd0,
      PH_DATA     = 2'd1,
      PH_FINISHED = 2'd2,
      PH_ERROR    = 2'd3
   } phase_type;

   logic [FIELD_WIDTH-1:0] counter_top_ff, response_min_ff, response_max_ff, one_threshold_ff;

   // input stage
   logic                   in_valid_ff, in_valid_in;
   logic                   in_op_ff;
   logic [FIELD_WIDTH-1:0] in_capture_ff;
   logic                   in_line_high_ff;

   // decoder state
   phase_type              phase_ff, phase_in;
   logic [FIELD_WIDTH-1:0] prev_capture_ff, prev_capture_in;
   logic [2:0]             bit_count_ff, bit_count_in;
   logic [2:0]             byte_count_ff, byte_count_in;
   logic [7:0]             shift_byte_ff, shift_byte_in;
   logic [7:0]             data_bytes_ff [4];
   logic                   byte_write;

   // result register
   logic                          out_valid_ff, out_valid_in;
   status_type                    status_ff, status_in;
   logic [FIELD_WIDTH-1:0]        humidity_ff, humidity_in;
   logic signed [FIELD_WIDTH-1:0] temperature_ff, temperature_in;
   logic                          emit;

   logic                   out_free, advance;
   logic [FIELD_WIDTH-1:0] capture_masked, interval;
   logic                   data_bit;
   logic [7:0]             shifted;
   logic [7:0]             checksum;
   logic [FIELD_WIDTH-1:0] temp_word;
   logic [FIELD_WIDTH-1:0] mag_temp;

   dhtpfd_interval #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_interval (
      .capture_value (in_capture_ff),
      .prev_capture  (prev_capture_ff),
      .counter_top   (counter_top_ff),
      .capture_masked(capture_masked),
      .interval      (interval)
   );

   assign out_free       = !out_valid_ff || rsp_port.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_port.ready = !in_valid_ff || out_free;
   assign csr_port.ready = 1'b1;

   assign data_bit  = interval > one_threshold_ff;
   assign shifted   = {shift_byte_ff[6:0], data_bit};
   assign checksum  = data_bytes_ff[0] + data_bytes_ff[1] + data_bytes_ff[2] + data_bytes_ff[3];
   assign temp_word = {data_bytes_ff[2], data_bytes_ff[3]};
   assign mag_temp  = {1'b0, temp_word[FIELD_WIDTH-2:0]};

   always_comb begin
      phase_in        = phase_ff;
      prev_capture_in = prev_capture_ff;
      bit_count_in    = bit_count_ff;
      byte_count_in   = byte_count_ff;
      shift_byte_in   = shift_byte_ff;
      byte_write      = 1'b0;
      emit            = 1'b0;
      status_in       = STATUS_UNEXPECTED;
      humidity_in     = '0;
      temperature_in  = '0;
      if (in_op_ff == OP_ARM) begin
         phase_in = PH_RESPONSE;
      end else begin
         prev_capture_in = capture_masked;
         if (!in_line_high_ff) begin
            unique case (phase_ff)
               PH_RESPONSE: begin
                  if (interval >= response_min_ff && interval < response_max_ff) begin
                     phase_in      = PH_DATA;
                     bit_count_in  = '0;
                     byte_count_in = '0;
                     shift_byte_in = '0;
                  end
               end
               PH_DATA: begin
                  bit_count_in  = bit_count_ff + 3'd1;
                  shift_byte_in = shifted;
                  // last bit of a byte
                  if (bit_count_ff == 3'd7) begin
                     byte_count_in = byte_count_ff + 3'd1;
                     shift_byte_in = '0;
                     if (byte_count_ff < 3'd4) begin
                        byte_write = 1'b1;
                     end else if (byte_count_ff == 3'd4) begin
                        emit = 1'b1;
                        if (shifted != checksum) begin
                           phase_in  = PH_ERROR;
                           status_in = STATUS_CHECKSUM;
                        end else begin
                           phase_in       = PH_FINISHED;
                           status_in      = STATUS_OK;
                           humidity_in    = {data_bytes_ff[0], data_bytes_ff[1]};
                           // sign-magnitude to two's complement, negative zero gives zero
                           temperature_in = temp_word[FIELD_WIDTH-1] ? -$signed(mag_temp)
                                                                     : $signed(mag_temp);
                        end
                     end else begin
                        emit     = 1'b1;
                        phase_in = PH_ERROR;
                     end
                  end
               end
               PH_FINISHED, PH_ERROR: begin
                  emit     = 1'b1;
                  phase_in = PH_ERROR;
               end
            endcase
         end
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = emit;
      end else if (rsp_port.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      if (req_port.valid && req_port.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_top_ff   <= COUNTER_TOP_RESET;
         response_min_ff  <= RESPONSE_MIN_RESET;
         response_max_ff  <= RESPONSE_MAX_RESET;
         one_threshold_ff <= ONE_THRESHOLD_RESET;
      end else if (csr_port.valid && csr_port.ready) begin
         case (csr_port.index)
            REG_COUNTER_TOP:   counter_top_ff   <= csr_port.data;
            REG_RESPONSE_MIN:  response_min_ff  <= csr_port.data;
            REG_RESPONSE_MAX:  response_max_ff  <= csr_port.data;
            REG_ONE_THRESHOLD: one_threshold_ff <= csr_port.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         phase_ff        <= PH_FINISHED;
         prev_capture_ff <= '0;
         bit_count_ff    <= '0;
         byte_count_ff   <= '0;
         shift_byte_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff        <= phase_in;
            prev_capture_ff <= prev_capture_in;
            bit_count_ff    <= bit_count_in;
            byte_count_ff   <= byte_count_in;
            shift_byte_ff   <= shift_byte_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         in_op_ff        <= req_port.op;
         in_capture_ff   <= req_port.capture_value;
         in_line_high_ff <= req_port.line_high;
      end
      if (advance && byte_write) begin
         data_bytes_ff[byte_count_ff[1:0]] <= shifted;
      end
      if (advance && emit) begin
         status_ff      <= status_in;
         humidity_ff    <= humidity_in;
         temperature_ff <= temperature_in;
      end
   end

   assign rsp_port.valid              = out_valid_ff;
   assign rsp_port.status             = status_ff;
   assign rsp_port.humidity_tenths    = humidity_ff;
   assign rsp_port.temperature_tenths = temperature_ff;

   `DHTPFD_ASSERT_NOW(a_error_fields_zero, out_valid_ff && status_ff != STATUS_OK, humidity_ff == '0 && temperature_ff == '0)
   `DHTPFD_ASSERT_NEXT(a_good_frame_finishes, advance && emit && status_in == STATUS_OK, phase_ff == PH_FINISHED)
   `DHTPFD_ASSERT_NOW(a_empty_stage_ready, !in_valid_ff, req_port.ready)

endmodule

// ===== tb/dht_frame_checker.sv =====
`timescale 1ns / 1ps
// checker for the pulse frame decoder: predicts decoded readings and compares results
module dht_frame_checker
   import dhtpfd_pkg::*;
#(
   parameter int COUNTER_WIDTH = DEFAULT_COUNTER_WIDTH
) (
   input  logic  clock,
   input  logic  reset,
   dhtpfd_req_if req_mon,
   dhtpfd_rsp_if rsp_mon,
   dhtpfd_csr_if csr_mon,
   output int    mismatches,
   output int    outstanding
);

   localparam int unsigned COUNT_MASK = (COUNTER_WIDTH >= 32) ? 32'hFFFF_FFFF
                                        : (32'd1 << COUNTER_WIDTH) - 32'd1;

   typedef enum logic [1:0] {
      PHASE_RESPONSE = 2'd0,
      PHASE_DATA     = 2'd1,
      PHASE_FINISHED = 2'd2,
      PHASE_ERROR    = 2'd3
   } phase_type;

   typedef struct packed {
      status_type                    status;
      logic [FIELD_WIDTH-1:0]        humidity;
      logic signed [FIELD_WIDTH-1:0] temperature;
   } reading_type;

   logic [FIELD_WIDTH-1:0] counter_top;
   logic [FIELD_WIDTH-1:0] response_min;
   logic [FIELD_WIDTH-1:0] response_max;
   logic [FIELD_WIDTH-1:0] one_threshold;

   phase_type   phase;
   int          last_capture;
   logic [2:0]  bits_in_byte;
   logic [2:0]  bytes_done;
   logic [7:0]  shift_byte;
   logic [7:0]  frame_bytes [4];
   reading_type expected_readings [$];
   int          error_total = 0;

   // returns 1 when the capture completes a reading or flags an error
   function automatic bit decode_capture(input logic [FIELD_WIDTH-1:0] value,
                                         input logic line_high,
                                         output reading_type reading);
      int         count;
      int         top;
      int         interval;
      bit         found;
      logic [7:0] sum;
      logic [15:0] raw;
      reading = '0;
      found = 1'b0;
      count = int'(value & COUNT_MASK);
      top = int'(counter_top & COUNT_MASK);
      if (count >= last_capture) begin
         interval = count - last_capture;
      end else begin
         // counter wrapped once since the previous capture
         interval = top - last_capture + count + 1;
         if (interval < 0) interval = 0;
      end
      last_capture = count;
      if (line_high) return 1'b0;

      case (phase)
         PHASE_RESPONSE: begin
            if (interval >= int'(response_min) && interval < int'(response_max)) begin
               phase = PHASE_DATA;
               bits_in_byte = '0;
               bytes_done = '0;
               shift_byte = '0;
            end
         end
         PHASE_DATA: begin
            shift_byte = {shift_byte[6:0], interval > int'(one_threshold)};
            bits_in_byte = bits_in_byte + 3'd1;
            if (bits_in_byte == 3'd0) begin
               if (bytes_done < 3'd4) begin
                  frame_bytes[bytes_done[1:0]] = shift_byte;
               end else if (bytes_done == 3'd4) begin
                  sum = frame_bytes[0] + frame_bytes[1] + frame_bytes[2] + frame_bytes[3];
                  found = 1'b1;
                  if (shift_byte != sum) begin
                     phase = PHASE_ERROR;
                     reading.status = STATUS_CHECKSUM;
                  end else begin
                     raw = {frame_bytes[2], frame_bytes[3]};
                     phase = PHASE_FINISHED;
                     reading.status = STATUS_OK;
                     reading.humidity = {frame_bytes[0], frame_bytes[1]};
                     // sign-magnitude to two's complement, negative zero folds to zero
                     reading.temperature = raw[15] ? 16'h0000 - {1'b0, raw[14:0]}
                                                   : {1'b0, raw[14:0]};
                  end
               end else begin
                  found = 1'b1;
                  phase = PHASE_ERROR;
                  reading.status = STATUS_UNEXPECTED;
               end
               bytes_done = bytes_done + 3'd1;
               shift_byte = '0;
            end
         end
         default: begin
            found = 1'b1;
            phase = PHASE_ERROR;
            reading.status = STATUS_UNEXPECTED;
         end
      endcase
      return found;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         counter_top = COUNTER_TOP_RESET;
         response_min = RESPONSE_MIN_RESET;
         response_max = RESPONSE_MAX_RESET;
         one_threshold = ONE_THRESHOLD_RESET;
         phase = PHASE_FINISHED;
         last_capture = 0;
         bits_in_byte = '0;
         bytes_done = '0;
         shift_byte = '0;
         expected_readings.delete();
      end else begin
         // results first: a word accepted at this edge cannot be answered at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_readings.size() == 0) begin
               $display("%0t unexpected reading: status %0d humidity %0d temperature %0d",
                        $time, rsp_mon.status, rsp_mon.humidity_tenths,
                        rsp_mon.temperature_tenths);
               error_total++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $display("%0t status: expected %0d, actual %0d",
                           $time, want.status, rsp_mon.status);
                  error_total++;
               end
               if (rsp_mon.humidity_tenths !== want.humidity) begin
                  $display("%0t humidity_tenths: expected %0d, actual %0d",
                           $time, want.humidity, rsp_mon.humidity_tenths);
                  error_total++;
               end
               if (rsp_mon.temperature_tenths !== want.temperature) begin
                  $display("%0t temperature_tenths: expected %0d, actual %0d",
                           $time, want.temperature, rsp_mon.temperature_tenths);
                  error_total++;
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_COUNTER_TOP:   counter_top = csr_mon.data;
               REG_RESPONSE_MIN:  response_min = csr_mon.data;
               REG_RESPONSE_MAX:  response_max = csr_mon.data;
               REG_ONE_THRESHOLD: one_threshold = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.op == OP_ARM) begin
               phase = PHASE_RESPONSE;
            end else if (decode_capture(req_mon.capture_value, req_mon.line_high, want)) begin
               expected_readings.push_back(want);
            end
         end
      end
      mismatches <= error_total;
      outstanding <= expected_readings.size();
   end

endmodule

// ===== tb/dht_pulse_frame_decoder_tb.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the pulse frame decoder
module dht_pulse_frame_decoder_tb
   import dhtpfd_pkg::*;
   ;

   localparam int ITEM_GOAL    = 650;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_TICKS = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dhtpfd_req_if req_bus ();
   dhtpfd_rsp_if rsp_bus ();
   dhtpfd_csr_if csr_bus ();

   int mismatch_count;
   int readings_pending;

   int items_sent = 0;
   int send_idle_pct = 20;
   int recv_stall_pct = 55;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int stamp = 0;

   logic [FIELD_WIDTH-1:0] cfg_top       = COUNTER_TOP_RESET;
   logic [FIELD_WIDTH-1:0] cfg_min       = RESPONSE_MIN_RESET;
   logic [FIELD_WIDTH-1:0] cfg_max       = RESPONSE_MAX_RESET;
   logic [FIELD_WIDTH-1:0] cfg_threshold = ONE_THRESHOLD_RESET;

   dht_pulse_frame_decoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   dht_frame_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .mismatches  (mismatch_count),
      .outstanding (readings_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // result side: random stalls plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_item(input logic op, input logic [FIELD_WIDTH-1:0] value,
                            input logic line_high);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.capture_value <= value;
      req_bus.line_high <= line_high;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (op == OP_CAPTURE) stamp = value;
      if (items_sent < 220) begin
         send_idle_pct = 20;
         recv_stall_pct = 55;
      end else if (items_sent < 440) begin
         send_idle_pct = 55;
         recv_stall_pct = 20;
      end else begin
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end
   endtask

   // capture that lands the given number of ticks after the last one
   task automatic send_interval(input int ticks, input logic line_high);
      int value;
      value = stamp + ticks;
      if (value > int'(cfg_top)) value -= int'(cfg_top) + 1;
      send_item(OP_CAPTURE, FIELD_WIDTH'(value), line_high);
   endtask

   task automatic send_frame(input bit complete);
      logic [7:0] frame_bytes [5];
      int         bit_total;
      int         ticks;
      int         top;
      int         upper;
      logic       data_bit;
      top = int'(cfg_top);
      for (int i = 0; i < 4; i++) frame_bytes[i] = 8'($urandom);
      case ($urandom_range(7))
         0: begin
            // negative zero temperature, zero humidity
            frame_bytes[0] = 8'h00;
            frame_bytes[1] = 8'h00;
            frame_bytes[2] = 8'h80;
            frame_bytes[3] = 8'h00;
         end
         1: for (int i = 0; i < 4; i++) frame_bytes[i] = 8'hFF;
         2: begin
            frame_bytes[2] = 8'h7F;
            frame_bytes[3] = 8'hFF;
         end
         3: frame_bytes[2] = frame_bytes[2] | 8'h80;
         default: ;
      endcase
      frame_bytes[4] = frame_bytes[0] + frame_bytes[1] + frame_bytes[2] + frame_bytes[3];
      if ($urandom_range(3) == 0) frame_bytes[4] ^= 8'($urandom_range(255, 1));
      bit_total = complete ? 40 : $urandom_range(39, 1);

      send_item(OP_ARM, FIELD_WIDTH'($urandom), 1'($urandom));
      // line-high capture puts the base back inside the counter range
      send_item(OP_CAPTURE, FIELD_WIDTH'($urandom_range(top)), 1'b1);
      if ($urandom_range(4) == 0) begin
         ticks = $urandom_range(top);
         if (!(ticks >= int'(cfg_min) && ticks < int'(cfg_max))) send_interval(ticks, 1'b0);
      end
      if (cfg_min < cfg_max && int'(cfg_min) <= top) begin
         upper = (int'(cfg_max) - 1 < top) ? int'(cfg_max) - 1 : top;
         ticks = $urandom_range(upper, int'(cfg_min));
      end else begin
         ticks = $urandom_range(top);
      end
      send_interval(ticks, 1'b0);

      for (int k = 0; k < bit_total; k++) begin
         data_bit = frame_bytes[k / 8][7 - (k % 8)];
         if ($urandom_range(4) == 0) send_interval($urandom_range(top), 1'b1);
         upper = (int'(cfg_threshold) < top) ? int'(cfg_threshold) : top;
         if (data_bit && int'(cfg_threshold) < top) begin
            ticks = ($urandom_range(3) == 0) ? upper + 1 : $urandom_range(top, upper + 1);
         end else begin
            ticks = ($urandom_range(3) == 0) ? upper : $urandom_range(upper);
         end
         send_interval(ticks, 1'b0);
      end
      if (complete && $urandom_range(2) == 0) send_interval($urandom_range(top), 1'b0);
   endtask

   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++) begin
         send_item(($urandom_range(3) == 0) ? OP_ARM : OP_CAPTURE,
                   FIELD_WIDTH'($urandom), 1'($urandom));
      end
   endtask

   task automatic run_traffic(input int until_items);
      while (items_sent < until_items) begin
         if ($urandom_range(9) < 7) send_frame($urandom_range(4) != 0);
         else send_noise($urandom_range(12, 3));
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (readings_pending != 0) @(posedge clock);
      // words with no result may still be in flight
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_settings(input logic [FIELD_WIDTH-1:0] top,
                                 input logic [FIELD_WIDTH-1:0] min_ticks,
                                 input logic [FIELD_WIDTH-1:0] max_ticks,
                                 input logic [FIELD_WIDTH-1:0] threshold);
      logic [CSR_INDEX_WIDTH-1:0] regs [4];
      logic [FIELD_WIDTH-1:0]     vals [4];
      regs = '{REG_COUNTER_TOP, REG_RESPONSE_MIN, REG_RESPONSE_MAX, REG_ONE_THRESHOLD};
      vals = '{top, min_ticks, max_ticks, threshold};
      wait_drained();
      for (int i = 0; i < 4; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= regs[i];
         csr_bus.data <= vals[i];
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
      cfg_top = top;
      cfg_min = min_ticks;
      cfg_max = max_ticks;
      cfg_threshold = threshold;
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.op <= OP_CAPTURE;
      req_bus.capture_value <= '0;
      req_bus.line_high <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= REG_COUNTER_TOP;
      csr_bus.data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // unexpected edges after reset, wrap, response window edges, bit threshold
      send_item(OP_CAPTURE, 16'h0000, 1'b0);
      send_item(OP_CAPTURE, 16'hFFFF, 1'b1);
      send_item(OP_CAPTURE, 16'h0000, 1'b0);
      send_item(OP_ARM, 16'hFFFF, 1'b1);
      send_interval(10, 1'b0);
      send_interval(200, 1'b0);
      send_interval(95, 1'b0);
      send_interval(69, 1'b0);
      send_interval(80, 1'b1);
      send_interval(70, 1'b0);
      send_interval(50, 1'b0);
      send_interval(51, 1'b0);
      send_interval(0, 1'b0);
      send_interval(65535, 1'b0);
      send_interval(51, 1'b0);
      send_interval(50, 1'b0);
      send_interval(51, 1'b0);
      send_interval(50, 1'b0);
      send_item(OP_ARM, 16'h0000, 1'b0);

      run_traffic(170);
      write_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
      run_traffic(290);
      write_settings(16'd1, 16'd0, 16'd2, 16'd0);
      run_traffic(400);
      write_settings(16'd9999, 16'd100, 16'd200, 16'd150);
      run_traffic(510);
      // empty response window: frames never start
      write_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
      run_traffic(550);
      write_settings(COUNTER_TOP_RESET, RESPONSE_MIN_RESET, RESPONSE_MAX_RESET,
                     ONE_THRESHOLD_RESET);

      // long result stall while edges keep coming, each one an error result
      hold_request = 1'b1;
      send_frame(1'b1);
      for (int i = 0; i < 30; i++) send_item(OP_CAPTURE, FIELD_WIDTH'($urandom), 1'b0);
      run_traffic(ITEM_GOAL);

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && readings_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
